### design/mmd_pkg.sv
// ----------------------------------------------------------------------------
// Mirrored memory map decoder package
// Shared sizes, window bases, status codes and decode/clear structures.
// ----------------------------------------------------------------------------
package mmd_pkg;

  // Store sizes in bytes.
  localparam int unsigned LOW_STORE_BYTES  = 16384;
  localparam int unsigned HIGH_STORE_BYTES = 16384;

  // Each store is split into four byte lanes; a row holds one byte per lane.
  localparam int unsigned BYTE_LANES = 4;
  localparam int unsigned LOW_ROWS   = (LOW_STORE_BYTES + BYTE_LANES - 1) / BYTE_LANES;
  localparam int unsigned HIGH_ROWS  = (HIGH_STORE_BYTES + BYTE_LANES - 1) / BYTE_LANES;
  localparam int unsigned LOW_AW     = (LOW_ROWS > 1) ? $clog2(LOW_ROWS) : 1;
  localparam int unsigned HIGH_AW    = (HIGH_ROWS > 1) ? $clog2(HIGH_ROWS) : 1;
  localparam int unsigned CLR_AW     = (LOW_AW > HIGH_AW) ? LOW_AW : HIGH_AW;
  localparam int unsigned MAX_ROWS   = (LOW_ROWS > HIGH_ROWS) ? LOW_ROWS : HIGH_ROWS;
  localparam int unsigned OFF_W      = CLR_AW + 2;

  // Window bases and I/O register addresses.
  localparam logic [31:0] LOW_CACHED_BASE    = 32'h8000_0000;
  localparam logic [31:0] LOW_UNCACHED_BASE  = 32'hC000_0000;
  localparam logic [31:0] HIGH_CACHED_BASE   = 32'h9000_0000;
  localparam logic [31:0] HIGH_UNCACHED_BASE = 32'hD000_0000;
  localparam logic [31:0] IO_COLOR_ADDR      = 32'h0D00_0000;
  localparam logic [31:0] IO_BUTTONS_ADDR    = 32'h0D00_0004;
  localparam logic [31:0] IO_FREQ_ADDR       = 32'h0D00_0008;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PAST_END  = 2'd1;
  localparam logic [1:0] ST_UNMAPPED  = 2'd2;
  localparam logic [1:0] ST_READ_ONLY = 2'd3;

  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_LOW,
    TGT_HIGH,
    TGT_COLOR,
    TGT_BUTTONS,
    TGT_FREQ
  } target_e;

  typedef struct packed {
    target_e            target;
    logic               past_end;
    logic [OFF_W-1:0]   offset;
  } dec_t;

  typedef struct packed {
    logic              active;
    logic              low_en;
    logic              high_en;
    logic [CLR_AW-1:0] row;
  } clr_t;

endpackage

### design/mmd_ram.sv
// ----------------------------------------------------------------------------
// Byte lane RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/mmd_decode.sv
// ----------------------------------------------------------------------------
// Address decoder
// Maps a bus address onto a store window or an I/O register.
// ----------------------------------------------------------------------------
module mmd_decode (
  input  logic [31:0]  address_i,
  output mmd_pkg::dec_t dec_o
);

  logic [31:0] diff_lc, diff_lu, diff_hc, diff_hu;
  logic        hit_lc, hit_lu, hit_hc, hit_hu;
  logic [31:0] sel_diff;
  logic [31:0] low_last, high_last;

  assign diff_lc = address_i - mmd_pkg::LOW_CACHED_BASE;
  assign diff_lu = address_i - mmd_pkg::LOW_UNCACHED_BASE;
  assign diff_hc = address_i - mmd_pkg::HIGH_CACHED_BASE;
  assign diff_hu = address_i - mmd_pkg::HIGH_UNCACHED_BASE;

  // Addresses below a base wrap far above any store size.
  assign hit_lc = diff_lc < 32'(mmd_pkg::LOW_STORE_BYTES);
  assign hit_lu = diff_lu < 32'(mmd_pkg::LOW_STORE_BYTES);
  assign hit_hc = diff_hc < 32'(mmd_pkg::HIGH_STORE_BYTES);
  assign hit_hu = diff_hu < 32'(mmd_pkg::HIGH_STORE_BYTES);

  // First offset at which a word no longer fits.
  assign low_last  = 32'(mmd_pkg::LOW_STORE_BYTES - 3);
  assign high_last = 32'(mmd_pkg::HIGH_STORE_BYTES - 3);

  always_comb begin
    sel_diff       = '0;
    dec_o.target   = mmd_pkg::TGT_NONE;
    dec_o.past_end = 1'b0;
    if (hit_lc || hit_lu) begin
      sel_diff       = hit_lc ? diff_lc : diff_lu;
      dec_o.target   = mmd_pkg::TGT_LOW;
      dec_o.past_end = sel_diff >= low_last;
    end else if (hit_hc || hit_hu) begin
      sel_diff       = hit_hc ? diff_hc : diff_hu;
      dec_o.target   = mmd_pkg::TGT_HIGH;
      dec_o.past_end = sel_diff >= high_last;
    end else if (address_i == mmd_pkg::IO_COLOR_ADDR) begin
      dec_o.target = mmd_pkg::TGT_COLOR;
    end else if (address_i == mmd_pkg::IO_BUTTONS_ADDR) begin
      dec_o.target = mmd_pkg::TGT_BUTTONS;
    end else if (address_i == mmd_pkg::IO_FREQ_ADDR) begin
      dec_o.target = mmd_pkg::TGT_FREQ;
    end
    dec_o.offset = sel_diff[mmd_pkg::OFF_W-1:0];
  end

endmodule

### design/mmd_clear.sv
// ----------------------------------------------------------------------------
// Store clearing sweep
// Walks every row of both stores once after reset, writing zero.
// ----------------------------------------------------------------------------
module mmd_clear (
  input  logic          clk_i,
  input  logic          rst_ni,
  output mmd_pkg::clr_t clr_o
);

  localparam logic [mmd_pkg::CLR_AW:0] LastCnt  = (mmd_pkg::CLR_AW + 1)'(mmd_pkg::MAX_ROWS);
  localparam logic [mmd_pkg::CLR_AW:0] LowRows  = (mmd_pkg::CLR_AW + 1)'(mmd_pkg::LOW_ROWS);
  localparam logic [mmd_pkg::CLR_AW:0] HighRows = (mmd_pkg::CLR_AW + 1)'(mmd_pkg::HIGH_ROWS);

  logic [mmd_pkg::CLR_AW:0] cnt_q, cnt_d;
  logic                     active;

  assign active = cnt_q != LastCnt;
  assign cnt_d  = active ? cnt_q + 1'b1 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign clr_o.active  = active;
  assign clr_o.low_en  = active && (cnt_q < LowRows);
  assign clr_o.high_en = active && (cnt_q < HighRows);
  assign clr_o.row     = cnt_q[mmd_pkg::CLR_AW-1:0];

endmodule

### design/mirrored_memory_map_decoder.sv
// ----------------------------------------------------------------------------
// Mirrored memory map decoder
// One 32-bit bus access per transfer, decoded onto two byte stores (each
// seen through a cached and an uncached window) or three I/O registers.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ---------------------------------------
//   in       in_valid_i/in_ready_o  action_i, address_i, write_word_i,
//                                   button_lines_i
//   out      out_valid_o/out_ready_i read_word_o, status_o,
//                                   background_color_o, tone_frequency_o
//
// A transfer in is decoded and its RAM read issued into the middle stage;
// it then lands in the output register, where its result is offered until
// the output side takes it.
// When the output side keeps taking results, one access is accepted every
// cycle; each byte-lane RAM of the addressed store is read or written once
// per access that fits. After reset the stores are swept to zero one row
// per cycle over max(LOW_ROWS, HIGH_ROWS) = 4096 rows, in_ready_o held low.
// A stalled output holds the middle stage, which then holds the input.
//
module mirrored_memory_map_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [31:0] address_i,
  input  logic [31:0] write_word_i,
  input  logic [31:0] button_lines_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_word_o,
  output logic [1:0]  status_o,
  output logic [31:0] background_color_o,
  output logic [31:0] tone_frequency_o
);

  // Where the read word of an access in the middle stage comes from.
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_LOW,
    SRC_HIGH,
    SRC_DIRECT
  } src_e;

  mmd_pkg::dec_t dec;
  mmd_pkg::clr_t clr;

  logic in_fire;
  logic s1_adv;

  // Accept-side results.
  logic [1:0]  status_d;
  src_e        src_d;
  logic [31:0] direct_d;
  logic [31:0] color_d, freq_d;
  logic [31:0] color_q, freq_q;
  logic        store_ok;
  logic        low_we, low_re, high_we, high_re;

  // Middle stage: the RAM read data lines up with these registers.
  logic        s1_valid_q;
  logic [1:0]  s1_status_q;
  src_e        s1_src_q;
  logic [31:0] s1_direct_q;
  logic [1:0]  s1_lane_q;
  logic [31:0] s1_color_q, s1_freq_q;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q;
  logic [1:0]  out_status_q;
  logic [31:0] out_color_q, out_freq_q;

  logic [7:0]  low_rd  [mmd_pkg::BYTE_LANES];
  logic [7:0]  high_rd [mmd_pkg::BYTE_LANES];
  logic [31:0] asm_low, asm_high, s1_word;

  mmd_decode u_decode (
    .address_i (address_i),
    .dec_o     (dec)
  );

  mmd_clear u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_o  (clr)
  );

  // The middle stage moves on whenever the output register is free or drained.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr.active && (!s1_valid_q || s1_adv);
  assign in_fire    = in_valid_i && in_ready_o;

  assign store_ok = !dec.past_end;
  assign low_we   = in_fire && (dec.target == mmd_pkg::TGT_LOW) && store_ok && action_i;
  assign low_re   = in_fire && (dec.target == mmd_pkg::TGT_LOW) && store_ok && !action_i;
  assign high_we  = in_fire && (dec.target == mmd_pkg::TGT_HIGH) && store_ok && action_i;
  assign high_re  = in_fire && (dec.target == mmd_pkg::TGT_HIGH) && store_ok && !action_i;

  // Status, read source and register updates for the access being accepted.
  // Writes always return a zero read word.
  always_comb begin
    status_d = mmd_pkg::ST_UNMAPPED;
    src_d    = SRC_ZERO;
    direct_d = '0;
    color_d  = color_q;
    freq_d   = freq_q;
    case (dec.target)
      mmd_pkg::TGT_LOW: begin
        status_d = dec.past_end ? mmd_pkg::ST_PAST_END : mmd_pkg::ST_OK;
        if (store_ok && !action_i) begin
          src_d = SRC_LOW;
        end
      end
      mmd_pkg::TGT_HIGH: begin
        status_d = dec.past_end ? mmd_pkg::ST_PAST_END : mmd_pkg::ST_OK;
        if (store_ok && !action_i) begin
          src_d = SRC_HIGH;
        end
      end
      mmd_pkg::TGT_COLOR: begin
        status_d = mmd_pkg::ST_OK;
        if (action_i) begin
          color_d = write_word_i;
        end else begin
          src_d    = SRC_DIRECT;
          direct_d = color_q;
        end
      end
      mmd_pkg::TGT_BUTTONS: begin
        if (action_i) begin
          status_d = mmd_pkg::ST_READ_ONLY;
        end else begin
          status_d = mmd_pkg::ST_OK;
          src_d    = SRC_DIRECT;
          direct_d = button_lines_i;
        end
      end
      mmd_pkg::TGT_FREQ: begin
        status_d = mmd_pkg::ST_OK;
        if (action_i) begin
          freq_d = write_word_i;
        end else begin
          src_d    = SRC_DIRECT;
          direct_d = freq_q;
        end
      end
      default: begin
        status_d = mmd_pkg::ST_UNMAPPED;
      end
    endcase
  end

  // Byte lane b holds every store byte whose offset is b modulo four. A word
  // at any alignment touches each lane exactly once: lanes below the
  // starting lane take the next row. Words are big-endian, so the byte at
  // the lowest offset is the most significant one.
  for (genvar b = 0; b < mmd_pkg::BYTE_LANES; b++) begin : g_lane
    logic [1:0]                 k;
    logic [31:0]                wshift;
    logic                       wrap;
    logic [mmd_pkg::LOW_AW-1:0]  low_row;
    logic [mmd_pkg::HIGH_AW-1:0] high_row;

    assign k        = 2'(b) - dec.offset[1:0];
    assign wshift   = write_word_i >> {~k, 3'b000};
    assign wrap     = 2'(b) < dec.offset[1:0];
    assign low_row  = dec.offset[mmd_pkg::LOW_AW+1:2] + mmd_pkg::LOW_AW'(wrap);
    assign high_row = dec.offset[mmd_pkg::HIGH_AW+1:2] + mmd_pkg::HIGH_AW'(wrap);

    mmd_ram #(
      .WIDTH (8),
      .DEPTH (mmd_pkg::LOW_ROWS),
      .AW    (mmd_pkg::LOW_AW)
    ) u_low (
      .clk_i   (clk_i),
      .we_i    (clr.low_en || low_we),
      .waddr_i (clr.active ? clr.row[mmd_pkg::LOW_AW-1:0] : low_row),
      .wdata_i (clr.active ? 8'h00 : wshift[7:0]),
      .re_i    (low_re),
      .raddr_i (low_row),
      .rdata_o (low_rd[b])
    );

    mmd_ram #(
      .WIDTH (8),
      .DEPTH (mmd_pkg::HIGH_ROWS),
      .AW    (mmd_pkg::HIGH_AW)
    ) u_high (
      .clk_i   (clk_i),
      .we_i    (clr.high_en || high_we),
      .waddr_i (clr.active ? clr.row[mmd_pkg::HIGH_AW-1:0] : high_row),
      .wdata_i (clr.active ? 8'h00 : wshift[7:0]),
      .re_i    (high_re),
      .raddr_i (high_row),
      .rdata_o (high_rd[b])
    );
  end

  // I/O registers change in accept order; each access carries a snapshot of
  // them as they stand after it, so a later write cannot leak into its result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= '0;
      freq_q  <= '0;
    end else if (in_fire) begin
      color_q <= color_d;
      freq_q  <= freq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_status_q <= status_d;
      s1_src_q    <= src_d;
      s1_direct_q <= direct_d;
      s1_lane_q   <= dec.offset[1:0];
      s1_color_q  <= color_d;
      s1_freq_q   <= freq_d;
    end
  end

  // Reassemble the word from the lanes, starting at the lane of its first byte.
  always_comb begin
    logic [1:0] lane;
    asm_low  = '0;
    asm_high = '0;
    for (int k = 0; k < 4; k++) begin
      lane = s1_lane_q + 2'(k);
      asm_low[8*(3-k) +: 8]  = low_rd[lane];
      asm_high[8*(3-k) +: 8] = high_rd[lane];
    end
  end

  always_comb begin
    case (s1_src_q)
      SRC_LOW:    s1_word = asm_low;
      SRC_HIGH:   s1_word = asm_high;
      SRC_DIRECT: s1_word = s1_direct_q;
      default:    s1_word = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_word_q   <= s1_word;
      out_status_q <= s1_status_q;
      out_color_q  <= s1_color_q;
      out_freq_q   <= s1_freq_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign read_word_o        = out_word_q;
  assign status_o           = out_status_q;
  assign background_color_o = out_color_q;
  assign tone_frequency_o   = out_freq_q;

endmodule

### dv/mirrored_memory_map_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mirrored memory map decoder testbench
// Sends bus reads and writes into the decoder and checks every result against
// an in-bench byte-level model of both stores and the I/O registers. The
// stimulus is a directed opening sequence followed by random accesses aimed
// at the windows, their boundaries, the I/O registers and the unmapped space.
// Both handshakes idle at random, and the output side stalls once for a long
// stretch.
// ----------------------------------------------------------------------------
module mirrored_memory_map_decoder_test;

  // Bus access direction, as carried on action_i.
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam int RANDOM_ACCESSES = 1625;
  // The limit on quiet cycles leaves plenty of room above both the post-reset
  // sweep of the stores and the long output stall.
  localparam int QUIET_LIMIT = 20000;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AFTER  = 600;
  localparam int CALM_TAIL   = 150;
  localparam int PHASE_LEN   = 150;

  typedef struct packed {
    logic        action;
    logic [31:0] address;
    logic [31:0] write_word;
    logic [31:0] button_lines;
  } access_t;

  typedef struct packed {
    logic [31:0] read_word;
    logic [1:0]  status;
    logic [31:0] background_color;
    logic [31:0] tone_frequency;
  } bus_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  access_t     in_item = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [31:0] read_word_o;
  logic [1:0]  status_o;
  logic [31:0] background_color_o;
  logic [31:0] tone_frequency_o;

  mirrored_memory_map_decoder uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .action_i           (in_item.action),
    .address_i          (in_item.address),
    .write_word_i       (in_item.write_word),
    .button_lines_i     (in_item.button_lines),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .read_word_o        (read_word_o),
    .status_o           (status_o),
    .background_color_o (background_color_o),
    .tone_frequency_o   (tone_frequency_o)
  );

  // Model state: both stores byte by byte, plus the two writable registers.
  logic [7:0]  low_bytes  [mmd_pkg::LOW_STORE_BYTES];
  logic [7:0]  high_bytes [mmd_pkg::HIGH_STORE_BYTES];
  logic [31:0] color_reg;
  logic [31:0] freq_reg;

  access_t     access_queue [$];
  bus_result_t awaited [$];
  bus_result_t oldest;

  int total_items;
  int accepted_count;
  int checked_count;
  int reads_sent;
  int writes_sent;
  int mismatches;
  int status_count [4];
  int quiet_cycles;
  int send_gap;
  int hold_left;
  bit long_hold_done;
  logic in_taken = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Model of the decoder
  // --------------------------------------------------------------------------

  function automatic bit in_window(logic [31:0] addr, logic [31:0] base,
                                   int unsigned size);
    return (addr >= base) && ((addr - base) < size);
  endfunction

  // Performs one access on the model state and returns the result that the
  // decoder must produce for it. The register values in the result are the
  // ones after this access has taken effect.
  function automatic bus_result_t decode_access(access_t acc);
    bus_result_t      res;
    mmd_pkg::target_e tgt;
    int unsigned      off;
    int unsigned      size;

    res  = '0;
    off  = 0;
    size = 0;
    if (in_window(acc.address, mmd_pkg::LOW_CACHED_BASE, mmd_pkg::LOW_STORE_BYTES)) begin
      tgt = mmd_pkg::TGT_LOW;
      off = acc.address - mmd_pkg::LOW_CACHED_BASE;
    end else if (in_window(acc.address, mmd_pkg::LOW_UNCACHED_BASE,
                           mmd_pkg::LOW_STORE_BYTES)) begin
      tgt = mmd_pkg::TGT_LOW;
      off = acc.address - mmd_pkg::LOW_UNCACHED_BASE;
    end else if (in_window(acc.address, mmd_pkg::HIGH_CACHED_BASE,
                           mmd_pkg::HIGH_STORE_BYTES)) begin
      tgt = mmd_pkg::TGT_HIGH;
      off = acc.address - mmd_pkg::HIGH_CACHED_BASE;
    end else if (in_window(acc.address, mmd_pkg::HIGH_UNCACHED_BASE,
                           mmd_pkg::HIGH_STORE_BYTES)) begin
      tgt = mmd_pkg::TGT_HIGH;
      off = acc.address - mmd_pkg::HIGH_UNCACHED_BASE;
    end else if (acc.address == mmd_pkg::IO_COLOR_ADDR) begin
      tgt = mmd_pkg::TGT_COLOR;
    end else if (acc.address == mmd_pkg::IO_BUTTONS_ADDR) begin
      tgt = mmd_pkg::TGT_BUTTONS;
    end else if (acc.address == mmd_pkg::IO_FREQ_ADDR) begin
      tgt = mmd_pkg::TGT_FREQ;
    end else begin
      tgt = mmd_pkg::TGT_NONE;
    end

    case (tgt)
      mmd_pkg::TGT_LOW, mmd_pkg::TGT_HIGH: begin
        size = (tgt == mmd_pkg::TGT_LOW) ? mmd_pkg::LOW_STORE_BYTES
                                         : mmd_pkg::HIGH_STORE_BYTES;
        // The whole word must fit: a word whose last byte runs off the end
        // of the store is refused without touching it.
        if (off + 3 >= size) begin
          res.status = mmd_pkg::ST_PAST_END;
        end else begin
          res.status = mmd_pkg::ST_OK;
          // Big-endian: the lowest offset holds the most significant byte.
          for (int lane = 0; lane < 4; lane++) begin
            if (acc.action == ACT_WRITE) begin
              if (tgt == mmd_pkg::TGT_LOW) begin
                low_bytes[off + lane] = acc.write_word[31 - 8 * lane -: 8];
              end else begin
                high_bytes[off + lane] = acc.write_word[31 - 8 * lane -: 8];
              end
            end else begin
              res.read_word[31 - 8 * lane -: 8] =
                (tgt == mmd_pkg::TGT_LOW) ? low_bytes[off + lane] : high_bytes[off + lane];
            end
          end
        end
      end
      mmd_pkg::TGT_COLOR: begin
        res.status = mmd_pkg::ST_OK;
        if (acc.action == ACT_WRITE) begin
          color_reg = acc.write_word;
        end else begin
          res.read_word = color_reg;
        end
      end
      mmd_pkg::TGT_BUTTONS: begin
        if (acc.action == ACT_WRITE) begin
          res.status = mmd_pkg::ST_READ_ONLY;
        end else begin
          res.status    = mmd_pkg::ST_OK;
          res.read_word = acc.button_lines;
        end
      end
      mmd_pkg::TGT_FREQ: begin
        res.status = mmd_pkg::ST_OK;
        if (acc.action == ACT_WRITE) begin
          freq_reg = acc.write_word;
        end else begin
          res.read_word = freq_reg;
        end
      end
      default: begin
        res.status = mmd_pkg::ST_UNMAPPED;
      end
    endcase

    // A write never returns data, even when it succeeds.
    if (acc.action == ACT_WRITE) begin
      res.read_word = '0;
    end
    res.background_color = color_reg;
    res.tone_frequency   = freq_reg;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic add_access(logic action, logic [31:0] address, logic [31:0] data,
                            logic [31:0] buttons);
    access_t acc;
    acc.action       = action;
    acc.address      = address;
    acc.write_word   = data;
    acc.button_lines = buttons;
    access_queue.push_back(acc);
  endtask

  // Picks an address inside one store through either of its windows. Most
  // offsets fall in a small hot region, so reads often hit earlier writes,
  // and some sit right at the end of the store to hit the past-end refusal.
  function automatic logic [31:0] store_address(logic [31:0] cached_base,
                                                logic [31:0] uncached_base,
                                                int unsigned size);
    logic [31:0] base;
    int unsigned off;
    int unsigned pick;

    base = $urandom_range(0, 1) ? cached_base : uncached_base;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      off = $urandom_range(0, 47);
    end else if (pick < 8) begin
      off = $urandom_range(0, size - 1);
    end else begin
      off = $urandom_range(size - 14, size - 1);
    end
    return base + off;
  endfunction

  // Chance in percent that an idle burst starts. The run walks through
  // phases with no idling, light idling and heavy idling.
  function automatic int idle_percent(int phase);
    case (phase % 3)
      0:       return 0;
      1:       return 8;
      default: return 30;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("%0t ns: result %0d, %s: expected %h, got %h",
             $time, checked_count, what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Input side: the driver changes the payload at the falling edge and the
  // transfer is recorded at the rising edge where valid and ready meet.
  // --------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (accepted_count < total_items - CALM_TAIL &&
                   $urandom_range(1, 100) <= idle_percent(accepted_count / PHASE_LEN)) begin
        send_gap = $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (access_queue.size() != 0) begin
        in_item  <= access_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (in_valid && in_ready_o) begin
      awaited.push_back(decode_access(in_item));
      accepted_count++;
      if (in_item.action == ACT_WRITE) begin
        writes_sent++;
      end else begin
        reads_sent++;
      end
    end
    in_taken <= in_valid && in_ready_o;
  end

  // --------------------------------------------------------------------------
  // Output side: ready idles in bursts, and once, partway through the run,
  // it is held low long enough for the pipeline to fill and push back on the
  // input while the driver keeps offering accesses.
  // --------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && accepted_count >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (accepted_count < total_items - CALM_TAIL &&
                 $urandom_range(1, 100) <=
                 idle_percent((accepted_count + PHASE_LEN / 2) / PHASE_LEN)) begin
      hold_left = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every result transfer is checked against the oldest outstanding access.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready) begin
      checked_count++;
      if (awaited.size() == 0) begin
        report_mismatch("result with no access outstanding", '0, read_word_o);
      end else begin
        oldest = awaited.pop_front();
        status_count[oldest.status]++;
        if (read_word_o !== oldest.read_word) begin
          report_mismatch("read_word", oldest.read_word, read_word_o);
        end
        if (status_o !== oldest.status) begin
          report_mismatch("status", 32'(oldest.status), 32'(status_o));
        end
        if (background_color_o !== oldest.background_color) begin
          report_mismatch("background_color", oldest.background_color,
                          background_color_o);
        end
        if (tone_frequency_o !== oldest.tone_frequency) begin
          report_mismatch("tone_frequency", oldest.tone_frequency, tone_frequency_o);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel completes a transfer.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin
    logic [31:0] base;
    int unsigned pick;

    rst_ni = 1'b0;
    color_reg = '0;
    freq_reg  = '0;
    foreach (low_bytes[i]) low_bytes[i] = '0;
    foreach (high_bytes[i]) high_bytes[i] = '0;

    // Directed opening: the stores read zero after reset, a word written in
    // one window is seen through the mirror, unaligned words, the last word
    // that fits, words that run past the end, addresses just outside some
    // windows, every I/O register, and the refused write to the buttons.
    add_access(ACT_READ,  mmd_pkg::LOW_CACHED_BASE,       32'h0,         32'h0);
    add_access(ACT_WRITE, mmd_pkg::LOW_CACHED_BASE,       32'hFFFF_FFFF, 32'h0);
    add_access(ACT_READ,  mmd_pkg::LOW_UNCACHED_BASE,     32'h0,         32'h0);
    add_access(ACT_WRITE, mmd_pkg::LOW_UNCACHED_BASE + 1, 32'h1234_5678, 32'h0);
    add_access(ACT_READ,  mmd_pkg::LOW_CACHED_BASE,       32'h0,         32'h0);
    add_access(ACT_WRITE, mmd_pkg::HIGH_CACHED_BASE + 16380,   32'hA5A5_5A5A, 32'h0);
    add_access(ACT_READ,  mmd_pkg::HIGH_UNCACHED_BASE + 16380, 32'h0,         32'h0);
    add_access(ACT_READ,  mmd_pkg::HIGH_UNCACHED_BASE + 16381, 32'h0,         32'h0);
    add_access(ACT_WRITE, mmd_pkg::LOW_CACHED_BASE + 16383,    32'hFFFF_FFFF, 32'h0);
    add_access(ACT_READ,  mmd_pkg::LOW_CACHED_BASE + 16384,    32'h0,         32'h0);
    add_access(ACT_READ,  32'h7FFF_FFFF,                  32'h0,         32'h0);
    add_access(ACT_WRITE, 32'hFFFF_FFFF,                  32'hFFFF_FFFF, 32'h0);
    add_access(ACT_READ,  32'h0000_0000,                  32'h0,         32'h0);
    add_access(ACT_WRITE, mmd_pkg::IO_COLOR_ADDR,         32'hDEAD_BEEF, 32'h0);
    add_access(ACT_READ,  mmd_pkg::IO_COLOR_ADDR,         32'h0,         32'h0);
    add_access(ACT_WRITE, mmd_pkg::IO_FREQ_ADDR,          32'h0000_01B8, 32'h0);
    add_access(ACT_READ,  mmd_pkg::IO_FREQ_ADDR,          32'h0,         32'h0);
    add_access(ACT_READ,  mmd_pkg::IO_BUTTONS_ADDR,       32'h0,         32'hFFFF_FFFF);
    add_access(ACT_READ,  mmd_pkg::IO_BUTTONS_ADDR,       32'hFFFF_FFFF, 32'h0);
    add_access(ACT_WRITE, mmd_pkg::IO_BUTTONS_ADDR,       32'h5555_AAAA, 32'hFFFF_FFFF);
    add_access(ACT_READ,  mmd_pkg::IO_COLOR_ADDR + 1,     32'h0,         32'h0);
    add_access(ACT_READ,  mmd_pkg::IO_FREQ_ADDR + 4,      32'h0,         32'h0);
    add_access(ACT_WRITE, mmd_pkg::HIGH_CACHED_BASE,      32'h0,         32'h0);
    add_access(ACT_READ,  mmd_pkg::HIGH_UNCACHED_BASE - 1, 32'h0,        32'h0);
    add_access(ACT_WRITE, mmd_pkg::HIGH_UNCACHED_BASE + 16382, 32'h0F0F_F0F0, 32'h0);

    // Random part: mostly store accesses with random data, the rest spread
    // over the I/O registers, the window boundaries and the whole space.
    repeat (RANDOM_ACCESSES) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        base = store_address(mmd_pkg::LOW_CACHED_BASE, mmd_pkg::LOW_UNCACHED_BASE,
                             mmd_pkg::LOW_STORE_BYTES);
      end else if (pick < 55) begin
        base = store_address(mmd_pkg::HIGH_CACHED_BASE, mmd_pkg::HIGH_UNCACHED_BASE,
                             mmd_pkg::HIGH_STORE_BYTES);
      end else if (pick < 72) begin
        case ($urandom_range(0, 3))
          0:       base = mmd_pkg::IO_COLOR_ADDR;
          1:       base = mmd_pkg::IO_BUTTONS_ADDR;
          2:       base = mmd_pkg::IO_FREQ_ADDR;
          default: base = mmd_pkg::IO_COLOR_ADDR + $urandom_range(1, 11);
        endcase
      end else if (pick < 85) begin
        // Just below a window or around its far end.
        case ($urandom_range(0, 3))
          0:       base = mmd_pkg::LOW_CACHED_BASE;
          1:       base = mmd_pkg::LOW_UNCACHED_BASE;
          2:       base = mmd_pkg::HIGH_CACHED_BASE;
          default: base = mmd_pkg::HIGH_UNCACHED_BASE;
        endcase
        if ($urandom_range(0, 1)) begin
          base = base - $urandom_range(1, 4);
        end else begin
          base = base + 16380 + $urandom_range(0, 7);
        end
      end else begin
        base = $urandom;
      end
      add_access($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, base, $urandom, $urandom);
    end
    total_items = access_queue.size();

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!(accepted_count == total_items && awaited.size() == 0) &&
           quiet_cycles < QUIET_LIMIT) begin
      @(negedge clk_i);
    end
    // A few more cycles so that a stray result would still be caught.
    if (quiet_cycles < QUIET_LIMIT) begin
      repeat (8) @(negedge clk_i);
    end

    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d of %0d accesses sent, %0d open",
               QUIET_LIMIT, accepted_count, total_items, awaited.size());
      $display("FAIL mirrored_memory_map_decoder");
    end else begin
      $display("Checked %0d results for %0d reads and %0d writes, %0d mismatches.",
               checked_count, reads_sent, writes_sent, mismatches);
      $display("Status seen: ok %0d, past end %0d, unmapped %0d, read-only %0d.",
               status_count[mmd_pkg::ST_OK], status_count[mmd_pkg::ST_PAST_END],
               status_count[mmd_pkg::ST_UNMAPPED], status_count[mmd_pkg::ST_READ_ONLY]);
      if (mismatches == 0) begin
        $display("PASS mirrored_memory_map_decoder");
      end else begin
        $display("FAIL mirrored_memory_map_decoder");
      end
    end
    $finish;
  end

endmodule
